// ===== rtl/core/palette_color_remap_unit_macros.svh =====
// Assertion macros shared by the palette color remap checker.
// Depends on nothing; included by the checker file.
`ifndef PALETTE_COLOR_REMAP_UNIT_MACROS_SVH
`define PALETTE_COLOR_REMAP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pcr_pkg.sv =====
// Shared types, constants and the recolor mapping for the palette remap unit.
// No dependencies.
`default_nettype none

package pcr_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
  localparam int COMP_W          = 8;
  localparam int RGB_W           = 3 * COMP_W;
  localparam int DIST_W          = 2 * COMP_W + 2;
  localparam int COLOR_W         = 8;

  localparam logic [COLOR_W-1:0] SHADOW_IDX = 8'd109;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_SEARCH  = 2'd1,
    OP_RECOLOR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    MODE_NONE  = 3'd0,
    MODE_DARK  = 3'd1,
    MODE_GRAY  = 3'd2,
    MODE_GREEN = 3'd3,
    MODE_GOLD  = 3'd4,
    MODE_RED   = 3'd5,
    MODE_BLUE  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } dist_req_t;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dist_sq;
  } dist_rsp_t;

  // Integer form of the HSV round trip; v is the largest component.
  function automatic rgb_t recolor_map(rgb_t c, mode_t m);
    logic [COMP_W-1:0]   v;
    logic [COMP_W+1:0]   v3;
    rgb_t                o;
    v = c.r;
    if (c.g > v) v = c.g;
    if (c.b > v) v = c.b;
    v3 = {2'b00, v} + {1'b0, v, 1'b0};
    unique case (m)
      MODE_DARK:  o = '{r: c.r >> 1, g: c.g >> 1, b: c.b >> 1};
      MODE_GRAY:  o = '{r: v, g: v, b: v};
      MODE_GREEN: o = '{r: '0, g: v, b: v >> 2};
      MODE_GOLD:  o = '{r: v, g: v3[COMP_W+1:2], b: '0};
      MODE_RED:   o = '{r: v, g: '0, b: '0};
      default:    o = '{r: '0, g: '0, b: v};
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pcr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pcr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcr_dist.sv =====
// Shared squared-distance unit: one palette entry against the target per cycle.
// Depends on pcr_pkg.
`default_nettype none

module pcr_dist
  import pcr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire dist_req_t req,
  input  wire rgb_t      pix,
  input  wire rgb_t      tgt,
  output dist_rsp_t      rsp
);

  logic [COMP_W-1:0]   ad_r, ad_g, ad_b;
  logic [2*COMP_W-1:0] sq_r, sq_g, sq_b;
  logic [DIST_W-1:0]   sum;
  logic                vld_r;
  logic [IDX_W-1:0]    idx_r;
  logic [DIST_W-1:0]   dist_r;

  always_comb begin
    ad_r = (tgt.r > pix.r) ? tgt.r - pix.r : pix.r - tgt.r;
    ad_g = (tgt.g > pix.g) ? tgt.g - pix.g : pix.g - tgt.g;
    ad_b = (tgt.b > pix.b) ? tgt.b - pix.b : pix.b - tgt.b;
    sq_r = ad_r * ad_r;
    sq_g = ad_g * ad_g;
    sq_b = ad_b * ad_b;
    sum  = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= req.vld;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= req.idx;
    dist_r <= sum;
  end

  assign rsp = '{vld: vld_r, idx: idx_r, dist_sq: dist_r};

endmodule

`default_nettype wire

// ===== rtl/core/pcr_ctrl.sv =====
// Sequencer: request decode, palette writes, source fetch, scan and best-match tracking.
// Depends on pcr_pkg.
`default_nettype none

module pcr_ctrl
  import pcr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [1:0]         in_operation,
  input  wire logic [7:0]         in_entry_index,
  input  wire logic [7:0]         in_red,
  input  wire logic [7:0]         in_green,
  input  wire logic [7:0]         in_blue,
  input  wire logic [2:0]         in_color_mode,
  input  wire logic               in_keep_shadow_gray,
  output logic                    busy,
  output logic                    out_valid,
  output logic [COLOR_W-1:0]      out_color_index,
  output logic                    ram_we,
  output logic [IDX_W-1:0]        ram_waddr,
  output logic [RGB_W-1:0]        ram_wdata,
  output logic [IDX_W-1:0]        ram_raddr,
  input  wire logic [RGB_W-1:0]   ram_rdata,
  output dist_req_t               dist_req,
  output rgb_t                    target,
  input  wire dist_rsp_t          dist_rsp
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                s1_vld_r, s1_vld_nxt;
  logic [IDX_W-1:0]    s1_idx_r, s1_idx_nxt;
  logic [DIST_W-1:0]   best_dist_r, best_dist_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  rgb_t                target_r, target_nxt;
  logic                src_ok_r, src_ok_nxt;
  mode_t               mode_r, mode_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]  result_r, result_nxt;

  logic accept, idx_ok, bypass, issuing, better, hit, last;
  rgb_t src_rgb;

  always_comb begin
    accept  = start && (state_r == ST_IDLE);
    idx_ok  = {1'b0, in_entry_index} < 9'(PALETTE_ENTRIES);
    bypass  = (in_color_mode == MODE_NONE) || (in_color_mode > MODE_BLUE) ||
              (in_keep_shadow_gray && (in_entry_index == SHADOW_IDX));
    issuing = cnt_r < CNT_W'(PALETTE_ENTRIES);
    better  = dist_rsp.vld && (dist_rsp.dist_sq < best_dist_r);
    hit     = dist_rsp.vld && (dist_rsp.dist_sq == '0);
    last    = dist_rsp.vld && (dist_rsp.idx == IDX_W'(PALETTE_ENTRIES - 1));
    src_rgb = src_ok_r ? rgb_t'(ram_rdata) : '0;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    s1_vld_nxt    = 1'b0;
    s1_idx_nxt    = s1_idx_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    target_nxt    = target_r;
    src_ok_nxt    = src_ok_r;
    mode_nxt      = mode_r;
    out_valid_nxt = 1'b0;
    result_nxt    = result_r;
    ram_we        = 1'b0;
    ram_raddr     = cnt_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = in_entry_index[IDX_W-1:0];
        if (accept) begin
          case (op_t'(in_operation))
            OP_WRITE: begin
              ram_we = idx_ok;
            end
            OP_SEARCH: begin
              target_nxt    = '{r: in_red, g: in_green, b: in_blue};
              cnt_nxt       = '0;
              best_dist_nxt = '1;
              state_nxt     = ST_SCAN;
            end
            OP_RECOLOR: begin
              if (bypass) begin
                out_valid_nxt = 1'b1;
                result_nxt    = in_entry_index;
              end else begin
                src_ok_nxt = idx_ok;
                mode_nxt   = mode_t'(in_color_mode);
                state_nxt  = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        // source entry is on the read port now
        target_nxt    = recolor_map(src_rgb, mode_r);
        cnt_nxt       = '0;
        best_dist_nxt = '1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        if (issuing) begin
          cnt_nxt    = cnt_r + 1'b1;
          s1_vld_nxt = 1'b1;
          s1_idx_nxt = cnt_r[IDX_W-1:0];
        end
        if (better) begin
          best_dist_nxt = dist_rsp.dist_sq;
          best_idx_nxt  = dist_rsp.idx;
        end
        if (hit || last) begin
          out_valid_nxt = 1'b1;
          result_nxt    = COLOR_W'(better ? dist_rsp.idx : best_idx_r);
          s1_vld_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    s1_idx_r    <= s1_idx_nxt;
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    target_r    <= target_nxt;
    src_ok_r    <= src_ok_nxt;
    mode_r      <= mode_nxt;
    result_r    <= result_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_color_index = result_r;
  assign ram_waddr       = in_entry_index[IDX_W-1:0];
  assign ram_wdata       = {in_red, in_green, in_blue};
  assign dist_req        = '{vld: s1_vld_r, idx: s1_idx_r};
  assign target          = target_r;

endmodule

`default_nettype wire

// ===== rtl/core/palette_color_remap_unit.sv =====
// Palette color remap unit: 256-entry RGB palette with write, nearest search and recolor.
// Results: a write gives none; a search result strobes once the palette scan ends,
//   sooner on an exact match; recolor adds a fetch state before its scan; a pass-through recolor
//   answers in the next cycle. Throughput: a search or a mapped recolor holds busy until its result strobes;
//   writes and pass-through recolors take one request per cycle.
// Reset: synchronous active-low rst_n clears the sequencer and the result strobe;
//   palette contents are kept. The receiver cannot stall the result strobe.
// Depends on pcr_pkg, pcr_ram, pcr_dist, pcr_ctrl.
`default_nettype none

module palette_color_remap_unit
  import pcr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // request channel: taken when start is high and busy is low
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_entry_index,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  input  wire logic [2:0] in_color_mode,
  input  wire logic       in_keep_shadow_gray,
  // result channel: one-cycle strobe, no backpressure
  output logic            out_valid,
  output logic [7:0]      out_color_index
);

  // Palette store port signals
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [RGB_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [RGB_W-1:0] ram_rdata;

  // Scan pipeline: read address -> palette read -> distance register -> compare
  dist_req_t dist_req;
  dist_rsp_t dist_rsp;
  rgb_t      target;

  // Palette memory. Contents are undefined until written; a search assumes
  // every entry it reads has been loaded.
  pcr_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // One distance per cycle against the registered target color.
  pcr_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dist_req),
    .pix   (rgb_t'(ram_rdata)),
    .tgt   (target),
    .rsp   (dist_rsp)
  );

  // Sequencer: decodes the request, fetches and maps the recolor source,
  // walks the palette and keeps the lowest-index minimum. A zero distance
  // ends the walk early.
  pcr_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .in_operation        (in_operation),
    .in_entry_index      (in_entry_index),
    .in_red              (in_red),
    .in_green            (in_green),
    .in_blue             (in_blue),
    .in_color_mode       (in_color_mode),
    .in_keep_shadow_gray (in_keep_shadow_gray),
    .busy                (busy),
    .out_valid           (out_valid),
    .out_color_index     (out_color_index),
    .ram_we              (ram_we),
    .ram_waddr           (ram_waddr),
    .ram_wdata           (ram_wdata),
    .ram_raddr           (ram_raddr),
    .ram_rdata           (ram_rdata),
    .dist_req            (dist_req),
    .target              (target),
    .dist_rsp            (dist_rsp)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pcr_checker.sv =====
// Port-level checker for the palette remap unit, bound to the top level.
// Depends on pcr_pkg and palette_color_remap_unit_macros.svh.
`default_nettype none
`include "palette_color_remap_unit_macros.svh"

module pcr_checker
  import pcr_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_operation,
  input wire logic       out_valid,
  input wire logic [7:0] out_color_index
);

  logic acc;
  assign acc = start && !busy;

  `PCR_ASSERT_NEXT(a_search_goes_busy, acc && (in_operation == OP_SEARCH), busy && !out_valid, "search request did not start a scan")
  `PCR_ASSERT_NEXT(a_write_no_result, acc && (in_operation == OP_WRITE), !busy && !out_valid, "palette write produced a result or stalled")
  `PCR_ASSERT_NOW(a_scan_end_result, $fell(busy), out_valid, "scan ended without a result strobe")
  `PCR_ASSERT_NOW(a_result_when_idle, out_valid, !busy && !$isunknown(out_color_index), "result strobe while busy or with unknown index")

endmodule

bind palette_color_remap_unit pcr_checker u_pcr_checker (.*);

`default_nettype wire

// ===== tb/palette_color_remap_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the palette color remap unit: watches the request and result ports,
// keeps a shadow palette, predicts each color index and compares it with the strobed one.
// Depends on pcr_pkg.

module palette_color_remap_checker
  import pcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_entry_index,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [2:0] in_color_mode,
  input  logic       in_keep_shadow_gray,
  input  logic       out_valid,
  input  logic [7:0] out_color_index,
  output int         mismatches,
  output int         outstanding,
  output int         results_checked
);

  rgb_t       palette_copy [PALETTE_ENTRIES];
  logic [7:0] color_index_q [$];
  int         fail_total = 0;
  int         waiting    = 0;
  int         seen_total = 0;

  assign mismatches      = fail_total;
  assign outstanding     = waiting;
  assign results_checked = seen_total;

  // Lowest index at the smallest squared distance; a zero distance stops the scan.
  function automatic logic [7:0] nearest_index(rgb_t want);
    int unsigned best_dist;
    int unsigned dist_sq;
    int          dr, dg, db;
    logic [7:0]  best;
    best      = '0;
    best_dist = 32'hFFFF_FFFF;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      dr      = int'(want.r) - int'(palette_copy[i].r);
      dg      = int'(want.g) - int'(palette_copy[i].g);
      db      = int'(want.b) - int'(palette_copy[i].b);
      dist_sq = int'(dr * dr + dg * dg + db * db);
      if (dist_sq == 0) return 8'(i);
      if (dist_sq < best_dist) begin
        best_dist = dist_sq;
        best      = 8'(i);
      end
    end
    return best;
  endfunction

  function automatic logic [7:0] recolor_index(logic [7:0] src, logic [2:0] mode,
                                               logic keep);
    rgb_t src_color;
    rgb_t mapped;
    int   peak;
    if (mode == MODE_NONE || mode > MODE_BLUE || (keep && src == SHADOW_IDX)) return src;
    src_color = (int'(src) < PALETTE_ENTRIES) ? palette_copy[src] : '0;
    peak = int'(src_color.r);
    if (int'(src_color.g) > peak) peak = int'(src_color.g);
    if (int'(src_color.b) > peak) peak = int'(src_color.b);
    mapped = '0;
    case (mode)
      MODE_DARK: begin
        mapped.r = src_color.r / 2;
        mapped.g = src_color.g / 2;
        mapped.b = src_color.b / 2;
      end
      MODE_GRAY: begin
        mapped.r = 8'(peak);
        mapped.g = 8'(peak);
        mapped.b = 8'(peak);
      end
      MODE_GREEN: begin
        mapped.g = 8'(peak);
        mapped.b = 8'(peak / 4);
      end
      MODE_GOLD: begin
        mapped.r = 8'(peak);
        mapped.g = 8'((3 * peak) / 4);
      end
      MODE_RED:  mapped.r = 8'(peak);
      default:   mapped.b = 8'(peak);
    endcase
    return nearest_index(mapped);
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n) begin
      // results first: a request's own answer never strobes at its accept edge
      if (out_valid) begin
        seen_total <= seen_total + 1;
        if (color_index_q.size() == 0) begin
          $error("color_index: no request waiting, actual %0d", out_color_index);
          fail_total <= fail_total + 1;
        end else begin
          want = color_index_q.pop_front();
          if (out_color_index !== want) begin
            $error("color_index: expected %0d, actual %0d", want, out_color_index);
            fail_total <= fail_total + 1;
          end
        end
      end
      if (start && !busy) begin
        case (in_operation)
          OP_WRITE: begin
            if (int'(in_entry_index) < PALETTE_ENTRIES)
              palette_copy[in_entry_index] = {in_red, in_green, in_blue};
          end
          OP_SEARCH:  color_index_q.push_back(nearest_index({in_red, in_green, in_blue}));
          OP_RECOLOR: color_index_q.push_back(recolor_index(in_entry_index, in_color_mode,
                                                            in_keep_shadow_gray));
          default: ;
        endcase
      end
      waiting <= color_index_q.size();
    end
  end

endmodule

// ===== tb/palette_color_remap_unit_test.sv =====
`timescale 1ns / 100ps
// Top of the palette color remap unit testbench: clock, reset, request stimulus and verdict.
// Depends on pcr_pkg, palette_color_remap_unit and palette_color_remap_checker.

module palette_color_remap_unit_test;
  import pcr_pkg::*;

  // codes the package leaves unnamed; both must be ignored or passed through
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  localparam int RANDOM_REQUESTS = 1630;
  localparam int QUIET_TAIL      = 300;      // last requests go back to back
  localparam int DRAIN_CYCLES    = 300;      // one full scan plus margin
  localparam int CYCLE_LIMIT     = 2_500_000;

  logic       clk                 = 1'b0;
  logic       rst_n               = 1'b0;
  logic       start               = 1'b0;
  logic [1:0] in_operation        = '0;
  logic [7:0] in_entry_index      = '0;
  logic [7:0] in_red              = '0;
  logic [7:0] in_green            = '0;
  logic [7:0] in_blue             = '0;
  logic [2:0] in_color_mode       = '0;
  logic       in_keep_shadow_gray = 1'b0;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_color_index;

  int mismatches;
  int outstanding;
  int results_checked;

  int  cycle_count = 0;
  bit  gaps_on     = 1'b1;
  int  n_write     = 0;
  int  n_search    = 0;
  int  n_recolor   = 0;
  int  n_unused    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  palette_color_remap_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_entry_index      (in_entry_index),
    .in_red              (in_red),
    .in_green            (in_green),
    .in_blue             (in_blue),
    .in_color_mode       (in_color_mode),
    .in_keep_shadow_gray (in_keep_shadow_gray),
    .out_valid           (out_valid),
    .out_color_index     (out_color_index)
  );

  palette_color_remap_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_entry_index      (in_entry_index),
    .in_red              (in_red),
    .in_green            (in_green),
    .in_blue             (in_blue),
    .in_color_mode       (in_color_mode),
    .in_keep_shadow_gray (in_keep_shadow_gray),
    .out_valid           (out_valid),
    .out_color_index     (out_color_index),
    .mismatches          (mismatches),
    .outstanding         (outstanding),
    .results_checked     (results_checked)
  );

  // Hard stop: several times the slowest clean run, even with a full scan per request.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("palette_color_remap_unit regression: fail");
      $finish;
    end
  end

  // Colors on a coarse grid (0/85/170/255) repeat often, which gives exact hits
  // and equal-distance ties; the rest are fully random.
  function automatic rgb_t pick_color();
    rgb_t c;
    if ($urandom_range(0, 9) < 4) begin
      c.r = 8'($urandom_range(0, 3) * 85);
      c.g = 8'($urandom_range(0, 3) * 85);
      c.b = 8'($urandom_range(0, 3) * 85);
    end else begin
      c.r = 8'($urandom_range(0, 255));
      c.g = 8'($urandom_range(0, 255));
      c.b = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  // start is only ever assigned once per edge, so back-to-back requests keep it high.
  task automatic issue_request(input logic [1:0] op, input logic [7:0] idx, input rgb_t color,
                               input logic [2:0] mode, input logic keep);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start               <= 1'b1;
    in_operation        <= op;
    in_entry_index      <= idx;
    in_red              <= color.r;
    in_green            <= color.g;
    in_blue             <= color.b;
    in_color_mode       <= mode;
    in_keep_shadow_gray <= keep;
    do @(posedge clk); while (busy);
    case (op)
      OP_WRITE:   n_write++;
      OP_SEARCH:  n_search++;
      OP_RECOLOR: n_recolor++;
      default:    n_unused++;
    endcase
    @(negedge clk);
  endtask

  task automatic random_request();
    int unsigned pick;
    logic [7:0]  idx;
    logic [2:0]  mode;
    logic        keep;
    pick = $urandom_range(0, 99);
    idx  = ($urandom_range(0, 9) == 0) ? SHADOW_IDX : 8'($urandom_range(0, 255));
    mode = 3'($urandom_range(0, 7));
    keep = 1'($urandom_range(0, 1));
    // fields a request ignores are still randomized so every port bit toggles
    if (pick < 38)       issue_request(OP_WRITE,   idx, pick_color(), mode, keep);
    else if (pick < 63)  issue_request(OP_SEARCH,  idx, pick_color(), mode, keep);
    else if (pick < 95)  issue_request(OP_RECOLOR, idx, pick_color(), mode, keep);
    else                 issue_request(OP_UNUSED,  idx, pick_color(), mode, keep);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Before the palette is filled only requests that read no entry are allowed:
    // unused opcode, mode none, unused mode and the kept shadow gray entry.
    issue_request(OP_UNUSED,  8'hFF,      24'hFFFFFF, MODE_UNUSED, 1'b1);
    issue_request(OP_RECOLOR, 8'd0,       24'h000000, MODE_NONE,   1'b0);
    issue_request(OP_RECOLOR, 8'd255,     24'hFFFFFF, MODE_NONE,   1'b1);
    issue_request(OP_RECOLOR, 8'd42,      24'h123456, MODE_UNUSED, 1'b0);
    issue_request(OP_RECOLOR, SHADOW_IDX, 24'h000000, MODE_GOLD,   1'b1);

    // a search can read every entry of the palette, so write all of it first
    for (int i = 0; i < PALETTE_ENTRIES; i++)
      issue_request(OP_WRITE, 8'(i), pick_color(), 3'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)));

    // Directed: extremes, duplicate colors (tie to lowest index), an equal-distance
    // tie, every recolor mode, and shadow gray with the keep bit on and off.
    issue_request(OP_WRITE,   8'd0,       24'h000000, MODE_NONE, 1'b0);
    issue_request(OP_WRITE,   8'd255,     24'hFFFFFF, MODE_NONE, 1'b0);
    issue_request(OP_WRITE,   8'd3,       {8'd100, 8'd100, 8'd100}, MODE_NONE, 1'b0);
    issue_request(OP_WRITE,   8'd4,       {8'd102, 8'd100, 8'd100}, MODE_NONE, 1'b0);
    issue_request(OP_WRITE,   8'd17,      {8'd40, 8'd80, 8'd120}, MODE_NONE, 1'b0);
    issue_request(OP_WRITE,   8'd200,     {8'd40, 8'd80, 8'd120}, MODE_NONE, 1'b0);
    issue_request(OP_SEARCH,  8'd0,       24'h000000, MODE_NONE, 1'b0);
    issue_request(OP_SEARCH,  8'd0,       24'hFFFFFF, MODE_NONE, 1'b0);
    issue_request(OP_SEARCH,  8'd0,       {8'd40, 8'd80, 8'd120}, MODE_NONE, 1'b0);
    issue_request(OP_SEARCH,  8'd0,       {8'd101, 8'd100, 8'd100}, MODE_NONE, 1'b0);
    for (int m = MODE_DARK; m <= MODE_BLUE; m++)
      issue_request(OP_RECOLOR, 8'd255, 24'h000000, 3'(m), 1'b0);
    issue_request(OP_RECOLOR, SHADOW_IDX, 24'h000000, MODE_DARK,   1'b1);
    issue_request(OP_RECOLOR, SHADOW_IDX, 24'h000000, MODE_GRAY,   1'b0);
    issue_request(OP_RECOLOR, 8'd17,      24'h000000, MODE_UNUSED, 1'b0);
    issue_request(OP_UNUSED,  8'hFF,      24'hFFFFFF, MODE_UNUSED, 1'b1);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS - QUIET_TAIL) gaps_on = 1'b0;
      random_request();
    end
    start <= 1'b0;

    // drain, then give a trailing request time to misbehave
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: %0d writes, %0d searches, %0d recolors, %0d unused opcodes",
             n_write, n_search, n_recolor, n_unused);
    $display("color indexes checked: %0d, mismatches: %0d", results_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("palette_color_remap_unit regression: pass");
    end else begin
      $display("palette_color_remap_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pcr_pkg.sv
rtl/core/pcr_ram.sv
rtl/core/pcr_dist.sv
rtl/core/pcr_ctrl.sv
rtl/core/palette_color_remap_unit.sv
rtl/core/pcr_checker.sv
tb/palette_color_remap_checker.sv
tb/palette_color_remap_unit_test.sv
